// File: src/prlm_pkg.sv
package prlm_pkg;

	// Build defaults
	localparam int MAX_SLOTS_DEF     = 1024;
	localparam int MAX_EMITS_DEF     = 16;
	localparam int FREE_LAG_DEF      = 3;

	// Fixed field widths
	localparam int STAMP_W   = 32;
	localparam int HEAD_W    = 10;
	localparam int LIMIT_W   = 11;
	localparam int DUR_W     = 26;
	localparam int PERIOD_W  = 20;
	localparam int ELAPSED_W = 20;
	localparam int EVENT_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 26;

	// Register reset values
	localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST = 11'd120;
	localparam logic [DUR_W-1:0]    DURATION_RST   = 26'd1000000;
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = 20'd16667;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYING    = 2'd3;

	// Item kinds
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Result event codes
	localparam logic [EVENT_W-1:0] EV_PLACED  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_DROPPED = 2'd1;
	localparam logic [EVENT_W-1:0] EV_FRAME   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_EMIT,
		ST_ADV,
		ST_RET_RD,
		ST_RET_CHK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_FIN
	} seq_state_t;

	// Fit a head index of any build width onto a 10-bit port
	function automatic logic [HEAD_W-1:0] to_port_head(input logic [31:0] v);
		return v[HEAD_W-1:0];
	endfunction

endpackage

// File: src/prlm_stamp_ram.sv
module prlm_stamp_ram #(
	parameter int DEPTH = prlm_pkg::MAX_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [prlm_pkg::STAMP_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [prlm_pkg::STAMP_W-1:0]  rdata
);

	logic [prlm_pkg::STAMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: src/particle_ring_lifetime_manager_core.sv
// Add item: the start beat moves the sequencer to ADD, which registers the result strobe; the next
//   start is taken in IDLE the cycle after ADD, so a new add waits until the last one is done.
// Frame tick: EMIT once per emission (skipped when not playing), ADV, then a read and a check
//   state per retired slot and per freed slot, then FIN.
// Results cannot be stalled; each is valid for one cycle. Reset clears heads, time,
//   frame count, accumulator and registers to their defaults; stamp RAM is not cleared.
module particle_ring_lifetime_manager_core #(
	parameter int MAX_SLOTS          = prlm_pkg::MAX_SLOTS_DEF,
	parameter int MAX_EMITS_PER_TICK = prlm_pkg::MAX_EMITS_DEF,
	parameter int FREE_LAG_FRAMES    = prlm_pkg::FREE_LAG_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  logic                             kind,
	input  logic [prlm_pkg::ELAPSED_W-1:0]   elapsed_us,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [prlm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [prlm_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	// result channel
	output logic                             res_valid,
	output logic [prlm_pkg::EVENT_W-1:0]     event_res,
	output logic [prlm_pkg::HEAD_W-1:0]      slot,
	output logic [prlm_pkg::STAMP_W-1:0]     birth_time_us,
	output logic [prlm_pkg::HEAD_W-1:0]      active_head,
	output logic [prlm_pkg::HEAD_W-1:0]      new_head,
	output logic [prlm_pkg::HEAD_W-1:0]      free_head,
	output logic [prlm_pkg::HEAD_W-1:0]      retired_head,
	output logic                             last
);

	localparam int HW = $clog2(MAX_SLOTS);            // head / RAM address width
	localparam int LW = HW + 1;                       // limit and walk step width
	localparam int KW = $clog2(MAX_EMITS_PER_TICK + 1);
	localparam int SW = prlm_pkg::STAMP_W;

	// Configuration registers
	logic [prlm_pkg::LIMIT_W-1:0]  slot_limit_q;
	logic [prlm_pkg::DUR_W-1:0]    duration_q;
	logic [prlm_pkg::PERIOD_W-1:0] period_q;
	logic                          playing_q;

	// Sequencer and ring state
	prlm_pkg::seq_state_t state_q, state_d;
	logic [HW-1:0] active_q, active_d;
	logic [HW-1:0] new_q, new_d;
	logic [HW-1:0] free_q, free_d;
	logic [HW-1:0] retired_q, retired_d;
	logic [SW-1:0] now_q, now_d;
	logic [SW-1:0] fc_q, fc_d;
	logic [SW-1:0] accum_q, accum_d;
	logic [LW-1:0] steps_q, steps_d;
	logic [KW-1:0] emit_cnt_q, emit_cnt_d;
	logic [prlm_pkg::ELAPSED_W-1:0] elapsed_q;

	// Stamp RAM port
	logic          mem_we;
	logic [HW-1:0] mem_waddr, mem_raddr;
	logic [SW-1:0] mem_wdata, mem_rdata;

	// Result capture
	logic                         res_load;
	logic                         do_add;
	logic [prlm_pkg::EVENT_W-1:0] res_event;
	logic [HW-1:0]                res_slot;
	logic [SW-1:0]                res_birth;
	logic                         res_last;

	logic [LW-1:0] lim;
	logic [HW-1:0] next_free;
	logic          ring_full;

	logic                         res_valid_q;
	logic [prlm_pkg::EVENT_W-1:0] event_q;
	logic [prlm_pkg::HEAD_W-1:0]  slot_q;
	logic [SW-1:0]                birth_q;
	logic [prlm_pkg::HEAD_W-1:0]  active_out_q, new_out_q, free_out_q, retired_out_q;
	logic                         last_q;

	// Advance a head by one, wrap to zero at the limit
	function automatic logic [HW-1:0] bump(input logic [HW-1:0] h, input logic [LW-1:0] l);
		logic [LW-1:0] n;
		n = {1'b0, h} + LW'(1);
		if (n >= l) begin
			n = '0;
		end
		return n[HW-1:0];
	endfunction

	// Clamp the programmed limit into 2..MAX_SLOTS
	always_comb begin
		if (slot_limit_q < 11'd2) begin
			lim = LW'(2);
		end else if (32'(slot_limit_q) > 32'(MAX_SLOTS)) begin
			lim = LW'(MAX_SLOTS);
		end else begin
			lim = LW'(slot_limit_q);
		end
	end

	assign next_free = bump(free_q, lim);
	assign ring_full = (next_free == retired_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= prlm_pkg::SLOT_LIMIT_RST;
			duration_q   <= prlm_pkg::DURATION_RST;
			period_q     <= prlm_pkg::PERIOD_RST;
			playing_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				prlm_pkg::REG_SLOT_LIMIT: slot_limit_q <= cfg_wdata[prlm_pkg::LIMIT_W-1:0];
				prlm_pkg::REG_DURATION:   duration_q   <= cfg_wdata[prlm_pkg::DUR_W-1:0];
				prlm_pkg::REG_PERIOD:     period_q     <= cfg_wdata[prlm_pkg::PERIOD_W-1:0];
				prlm_pkg::REG_PLAYING:    playing_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= prlm_pkg::ST_IDLE;
			active_q   <= '0;
			new_q      <= '0;
			free_q     <= '0;
			retired_q  <= '0;
			now_q      <= '0;
			fc_q       <= '0;
			accum_q    <= '0;
			steps_q    <= '0;
			emit_cnt_q <= '0;
		end else begin
			state_q    <= state_d;
			active_q   <= active_d;
			new_q      <= new_d;
			free_q     <= free_d;
			retired_q  <= retired_d;
			now_q      <= now_d;
			fc_q       <= fc_d;
			accum_q    <= accum_d;
			steps_q    <= steps_d;
			emit_cnt_q <= emit_cnt_d;
		end
	end

	// Hold the tick's elapsed time for the advance step
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			elapsed_q <= elapsed_us;
		end
	end

	// Next state, ring updates and result selection
	always_comb begin
		state_d    = state_q;
		active_d   = active_q;
		new_d      = new_q;
		free_d     = free_q;
		retired_d  = retired_q;
		now_d      = now_q;
		fc_d       = fc_q;
		accum_d    = accum_q;
		steps_d    = steps_q;
		emit_cnt_d = emit_cnt_q;
		mem_we     = 1'b0;
		mem_waddr  = free_q;
		mem_wdata  = now_q;
		mem_raddr  = active_q;
		do_add     = 1'b0;
		res_load   = 1'b0;
		res_event  = prlm_pkg::EV_FRAME;
		res_slot   = '0;
		res_birth  = '0;
		res_last   = 1'b0;

		case (state_q)
			prlm_pkg::ST_IDLE: begin
				if (start) begin
					if (kind == prlm_pkg::KIND_ADD) begin
						state_d = prlm_pkg::ST_ADD;
					end else begin
						emit_cnt_d = '0;
						if (playing_q) begin
							accum_d = accum_q + SW'(elapsed_us);
							state_d = prlm_pkg::ST_EMIT;
						end else begin
							state_d = prlm_pkg::ST_ADV;
						end
					end
				end
			end
			prlm_pkg::ST_ADD: begin
				do_add   = 1'b1;
				res_last = 1'b1;
				state_d  = prlm_pkg::ST_IDLE;
			end
			prlm_pkg::ST_EMIT: begin
				if (accum_q > SW'(period_q) && emit_cnt_q < KW'(MAX_EMITS_PER_TICK)) begin
					accum_d    = accum_q - SW'(period_q);
					emit_cnt_d = emit_cnt_q + KW'(1);
					do_add     = 1'b1;
				end else begin
					// clamp away the excess past the cap
					if (accum_q > SW'(period_q)) begin
						accum_d = SW'(period_q);
					end
					state_d = prlm_pkg::ST_ADV;
				end
			end
			prlm_pkg::ST_ADV: begin
				now_d   = now_q + SW'(elapsed_q);
				steps_d = '0;
				state_d = prlm_pkg::ST_RET_RD;
			end
			prlm_pkg::ST_RET_RD: begin
				if (steps_q < lim && active_q != new_q) begin
					mem_raddr = active_q;
					state_d   = prlm_pkg::ST_RET_CHK;
				end else begin
					steps_d = '0;
					state_d = prlm_pkg::ST_FREE_RD;
				end
			end
			prlm_pkg::ST_RET_CHK: begin
				if ((now_q - mem_rdata) < SW'(duration_q)) begin
					steps_d = '0;
					state_d = prlm_pkg::ST_FREE_RD;
				end else begin
					// retire: restamp with the frame count
					mem_we    = 1'b1;
					mem_waddr = active_q;
					mem_wdata = fc_q;
					active_d  = bump(active_q, lim);
					steps_d   = steps_q + LW'(1);
					state_d   = prlm_pkg::ST_RET_RD;
				end
			end
			prlm_pkg::ST_FREE_RD: begin
				if (steps_q < lim && retired_q != active_q) begin
					mem_raddr = retired_q;
					state_d   = prlm_pkg::ST_FREE_CHK;
				end else begin
					state_d = prlm_pkg::ST_FIN;
				end
			end
			prlm_pkg::ST_FREE_CHK: begin
				if ((fc_q - mem_rdata) < SW'(FREE_LAG_FRAMES)) begin
					state_d = prlm_pkg::ST_FIN;
				end else begin
					retired_d = bump(retired_q, lim);
					steps_d   = steps_q + LW'(1);
					state_d   = prlm_pkg::ST_FREE_RD;
				end
			end
			prlm_pkg::ST_FIN: begin
				if (active_q == free_q) begin
					now_d = '0;
				end
				fc_d      = ((retired_q == active_q) ? '0 : fc_q) + SW'(1);
				new_d     = free_q;
				res_load  = 1'b1;
				res_event = prlm_pkg::EV_FRAME;
				res_last  = 1'b1;
				state_d   = prlm_pkg::ST_IDLE;
			end
			default: begin
				state_d = prlm_pkg::ST_IDLE;
			end
		endcase

		// Place one particle at the free head, or drop it when the ring is full
		if (do_add) begin
			res_load = 1'b1;
			if (ring_full) begin
				res_event = prlm_pkg::EV_DROPPED;
			end else begin
				mem_we    = 1'b1;
				mem_waddr = free_q;
				mem_wdata = now_q;
				free_d    = next_free;
				res_event = prlm_pkg::EV_PLACED;
				res_slot  = free_q;
				res_birth = now_q;
			end
		end
	end

	prlm_stamp_ram #(
		.DEPTH (MAX_SLOTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result beat register: strobe for one cycle, heads as left by the action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			event_q       <= res_event;
			slot_q        <= prlm_pkg::to_port_head(32'(res_slot));
			birth_q       <= res_birth;
			active_out_q  <= prlm_pkg::to_port_head(32'(active_d));
			new_out_q     <= prlm_pkg::to_port_head(32'(new_d));
			free_out_q    <= prlm_pkg::to_port_head(32'(free_d));
			retired_out_q <= prlm_pkg::to_port_head(32'(retired_d));
			last_q        <= res_last;
		end
	end

	assign busy          = (state_q != prlm_pkg::ST_IDLE);
	assign res_valid     = res_valid_q;
	assign event_res     = event_q;
	assign slot          = slot_q;
	assign birth_time_us = birth_q;
	assign active_head   = active_out_q;
	assign new_head      = new_out_q;
	assign free_head     = free_out_q;
	assign retired_head  = retired_out_q;
	assign last          = last_q;

	// A final beat only shows once the sequencer is back to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last) |-> !busy)
		else $error("final result beat while still busy");

	// Emission beats come out mid-tick, never as the final beat
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last) |-> busy)
		else $error("non-final result beat outside an item");

	// Every item ends with exactly one final beat
	a_fell_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (res_valid && last))
		else $error("item finished without a final result beat");

	// Frame-done beat is always final
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && event_res == prlm_pkg::EV_FRAME) |-> last)
		else $error("frame done beat not marked last");

	// Emission count stays within the per-tick cap
	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= KW'(MAX_EMITS_PER_TICK))
		else $error("emission count past the per-tick cap");

endmodule

// File: tb/particle_ring_lifetime_manager_core_tb.sv
`timescale 1ns / 100ps

module particle_ring_lifetime_manager_core_tb;
	import prlm_pkg::*;

	// One result beat as the ring is expected to report it
	typedef struct {
		logic [EVENT_W-1:0]  ev;
		logic [HEAD_W-1:0]   slot;
		logic [STAMP_W-1:0]  birth;
		logic [HEAD_W-1:0]   active;
		logic [HEAD_W-1:0]   fresh;
		logic [HEAD_W-1:0]   free;
		logic [HEAD_W-1:0]   retired;
		logic                last;
	} ring_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  kind;
	logic [ELAPSED_W-1:0]  elapsed_us;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_wdata;
	logic                  res_valid;
	logic [EVENT_W-1:0]    event_res;
	logic [HEAD_W-1:0]     slot;
	logic [STAMP_W-1:0]    birth_time_us;
	logic [HEAD_W-1:0]     active_head;
	logic [HEAD_W-1:0]     new_head;
	logic [HEAD_W-1:0]     free_head;
	logic [HEAD_W-1:0]     retired_head;
	logic                  last;

	// Shadow copy of the ring: time base, frame counter, emission accumulator, heads
	logic [31:0]   slot_birth [MAX_SLOTS_DEF];
	logic [31:0]   ring_now;
	logic [31:0]   ring_frames;
	logic [31:0]   ring_accum;
	int unsigned   hd_active;
	int unsigned   hd_new;
	int unsigned   hd_free;
	int unsigned   hd_retired;

	// Shadow copy of the register file
	logic [LIMIT_W-1:0]   lim_reg;
	logic [31:0]          dur_reg;
	logic [31:0]          period_reg;
	logic                 play_reg;

	ring_beat_t   pending_beats [$];
	int           mismatches;
	int           idle_pct;

	particle_ring_lifetime_manager_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.elapsed_us    (elapsed_us),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.res_valid     (res_valid),
		.event_res     (event_res),
		.slot          (slot),
		.birth_time_us (birth_time_us),
		.active_head   (active_head),
		.new_head      (new_head),
		.free_head     (free_head),
		.retired_head  (retired_head),
		.last          (last)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Hard stop in case the block hangs or stops answering
	initial begin
		#40_000_000;
		$display("[particle_ring_lifetime_manager_core] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Ring predictor
	// ------------------------------------------------------------------

	// Clamp the limit register into the usable range of the ring
	function automatic int unsigned ring_span();
		int unsigned l;
		l = lim_reg;
		if (l < 2) l = 2;
		if (l > MAX_SLOTS_DEF) l = MAX_SLOTS_DEF;
		return l;
	endfunction

	// Advance a head by one, wrapping at the limit (stale heads wrap too)
	function automatic int unsigned ring_next(input int unsigned h);
		int unsigned n;
		n = h + 1;
		if (n >= ring_span()) n = 0;
		return n;
	endfunction

	task automatic post_beat(input logic [EVENT_W-1:0] ev, input int unsigned sl,
			input logic [31:0] birth);
		ring_beat_t b;
		b.ev      = ev;
		b.slot    = sl[HEAD_W-1:0];
		b.birth   = birth;
		b.active  = hd_active[HEAD_W-1:0];
		b.fresh   = hd_new[HEAD_W-1:0];
		b.free    = hd_free[HEAD_W-1:0];
		b.retired = hd_retired[HEAD_W-1:0];
		b.last    = 1'b0;
		pending_beats.push_back(b);
	endtask

	// Take the free slot and stamp it with the current time, or drop when full
	task automatic place_particle();
		int unsigned nxt;
		int unsigned sl;
		nxt = ring_next(hd_free);
		if (nxt == hd_retired) begin
			post_beat(EV_DROPPED, 0, 32'd0);
		end else begin
			sl = hd_free;
			slot_birth[sl] = ring_now;
			hd_free = nxt;
			post_beat(EV_PLACED, sl, ring_now);
		end
	endtask

	// Work out every beat that one accepted command causes
	task automatic ring_apply(input logic k, input logic [ELAPSED_W-1:0] el);
		int           emits;
		int unsigned  lim;
		int unsigned  steps;
		logic [31:0]  age;
		emits = 0;
		if (k == KIND_ADD) begin
			place_particle();
		end else begin
			// Emission: one add per whole period exceeded, capped, excess clamped
			if (play_reg) begin
				ring_accum += el;
				while (ring_accum > period_reg && emits < MAX_EMITS_DEF) begin
					ring_accum -= period_reg;
					place_particle();
					emits++;
				end
				if (ring_accum > period_reg) ring_accum = period_reg;
			end
			ring_now += el;
			lim = ring_span();
			// Retire published slots that reached their lifetime; restamp with the frame
			for (steps = 0; steps < lim && hd_active != hd_new; steps++) begin
				age = ring_now - slot_birth[hd_active];
				if (age < dur_reg) break;
				slot_birth[hd_active] = ring_frames;
				hd_active = ring_next(hd_active);
			end
			// Free retired slots old enough in frames
			for (steps = 0; steps < lim && hd_retired != hd_active; steps++) begin
				age = ring_frames - slot_birth[hd_retired];
				if (age < FREE_LAG_DEF) break;
				hd_retired = ring_next(hd_retired);
			end
			if (hd_active == hd_free) ring_now = 32'd0;
			if (hd_retired == hd_active) ring_frames = 32'd0;
			hd_new = hd_free;
			ring_frames++;
			post_beat(EV_FRAME, 0, 32'd0);
		end
		pending_beats[pending_beats.size()-1].last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Result checker: every strobed beat against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ring_beat_t want;
		if (arst_n && res_valid) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected beat, event", event_res, 0);
			end else begin
				want = pending_beats.pop_front();
				if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
				if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
				if (birth_time_us !== want.birth)
					report_mismatch("birth_time_us", birth_time_us, want.birth);
				if (active_head !== want.active)
					report_mismatch("active_head", active_head, want.active);
				if (new_head !== want.fresh) report_mismatch("new_head", new_head, want.fresh);
				if (free_head !== want.free) report_mismatch("free_head", free_head, want.free);
				if (retired_head !== want.retired)
					report_mismatch("retired_head", retired_head, want.retired);
				if (last !== want.last) report_mismatch("last", last, want.last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Send one command beat; idle at random first, then hold start until accepted
	task automatic push_command(input logic k, input logic [ELAPSED_W-1:0] el);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start      = 1'b0;
			kind       = 1'($urandom);
			elapsed_us = ELAPSED_W'($urandom);
			@(negedge clk);
		end
		start      = 1'b1;
		kind       = k;
		elapsed_us = el;
		// Accept on the first rising edge that sees busy low
		do @(posedge clk); while (busy);
		ring_apply(k, el);
	endtask

	// Drop start, wait for every expected beat, then let the block settle
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		start = 1'b0;
		while (pending_beats.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_beats.size() != 0) begin
			report_mismatch("beats never delivered", pending_beats.size(), 0);
			pending_beats.delete();
		end
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Write one register; only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(posedge clk);
		case (idx)
			REG_SLOT_LIMIT: lim_reg    = data[LIMIT_W-1:0];
			REG_DURATION:   dur_reg    = 32'(data[DUR_W-1:0]);
			REG_PERIOD:     period_reg = 32'(data[PERIOD_W-1:0]);
			REG_PLAYING:    play_reg   = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Empty the ring so all four heads meet; tests change the limit only right after
	// a drain, which keeps every walk on slots that were stamped by an add
	task automatic ring_drain();
		int n;
		n = 0;
		settle();
		write_reg(REG_PLAYING, '0);
		write_reg(REG_DURATION, CFG_DAT_W'(1));
		while (!(hd_active == hd_new && hd_new == hd_free && hd_free == hd_retired)
				&& n < 30) begin
			push_command(KIND_TICK, ELAPSED_W'(1000));
			n++;
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values: adds and ticks with emission stopped
	task automatic test_power_on();
		push_command(KIND_ADD, '0);
		push_command(KIND_ADD, '1);
		push_command(KIND_TICK, '0);
		push_command(KIND_TICK, '1);
		push_command(KIND_ADD, '0);
		push_command(KIND_TICK, ELAPSED_W'(1000000));
		settle();
	endtask

	// Limit below two acts as two; stale heads wrap into range, then the ring fills
	task automatic test_ring_full();
		ring_drain();
		write_reg(REG_SLOT_LIMIT, 26'h3FFF800);
		push_command(KIND_ADD, '0);
		push_command(KIND_ADD, '0);
		push_command(KIND_ADD, '0);
		push_command(KIND_TICK, ELAPSED_W'(5));
		ring_drain();
		push_command(KIND_ADD, '0);
		push_command(KIND_ADD, '0);
		push_command(KIND_ADD, '0);
		settle();
	endtask

	// Zero period, emission cap and clamp, strict compare against the period
	task automatic test_emission();
		ring_drain();
		write_reg(REG_SLOT_LIMIT, CFG_DAT_W'(2047));
		write_reg(REG_DURATION, '1);
		write_reg(REG_PERIOD, '0);
		write_reg(REG_PLAYING, 26'h3FFFFFF);
		push_command(KIND_TICK, ELAPSED_W'(5));
		push_command(KIND_TICK, '0);
		settle();
		write_reg(REG_PERIOD, CFG_DAT_W'(20'hFFFFF));
		push_command(KIND_TICK, '1);
		push_command(KIND_TICK, ELAPSED_W'(1));
		settle();
		write_reg(REG_PERIOD, CFG_DAT_W'(1));
		push_command(KIND_TICK, '1);
		settle();
		write_reg(REG_PERIOD, CFG_DAT_W'(1000000));
		push_command(KIND_TICK, ELAPSED_W'(1000000));
		push_command(KIND_TICK, ELAPSED_W'(1000000));
		settle();
	endtask

	// Lifetime expiry, frame restamp and release after the frame lag
	task automatic test_retire_free();
		ring_drain();
		write_reg(REG_SLOT_LIMIT, CFG_DAT_W'(8));
		write_reg(REG_DURATION, CFG_DAT_W'(3000));
		repeat (3) push_command(KIND_ADD, '0);
		push_command(KIND_TICK, ELAPSED_W'(1000));
		repeat (2) push_command(KIND_ADD, '0);
		push_command(KIND_TICK, ELAPSED_W'(2000));
		push_command(KIND_TICK, ELAPSED_W'(2000));
		repeat (3) push_command(KIND_TICK, '0);
		settle();
	endtask

	// Keep the ring alive over back-to-back ticks so emitted slots expire and recycle
	task automatic test_long_run();
		ring_drain();
		write_reg(REG_SLOT_LIMIT, CFG_DAT_W'(120));
		write_reg(REG_DURATION, CFG_DAT_W'(30000000));
		write_reg(REG_PERIOD, CFG_DAT_W'(1048574));
		write_reg(REG_PLAYING, CFG_DAT_W'(1));
		idle_pct = 0;
		repeat (40) push_command(KIND_TICK, '1);
		settle();
		idle_pct = 38;
	endtask

	// Random traffic across several register settings
	task automatic test_random_traffic();
		logic [LIMIT_W-1:0]    lim;
		logic [DUR_W-1:0]      dur;
		logic [PERIOD_W-1:0]   per;
		logic [ELAPSED_W-1:0]  el;
		for (int phase = 0; phase < 5; phase++) begin
			ring_drain();
			case (phase)
				0: lim = 11'd2047;
				1: lim = LIMIT_W'($urandom_range(1, 0));
				default: lim = LIMIT_W'($urandom_range(40, 3));
			endcase
			dur = (phase == 3) ? '0 : DUR_W'($urandom_range(400000, 1));
			per = PERIOD_W'($urandom_range(200000, 0));
			write_reg(REG_SLOT_LIMIT, {15'($urandom), lim});
			write_reg(REG_DURATION, dur);
			write_reg(REG_PERIOD, {6'($urandom), per});
			write_reg(REG_PLAYING, {25'($urandom), 1'(phase != 1)});
			// One phase runs back to back with no idle cycles
			idle_pct = (phase == 2) ? 0 : 38;
			repeat (18) begin
				if ($urandom_range(99) < 55) begin
					push_command(KIND_ADD, ELAPSED_W'($urandom));
				end else begin
					if ($urandom_range(99) < 80) el = ELAPSED_W'($urandom_range(150000, 0));
					else el = ELAPSED_W'($urandom);
					push_command(KIND_TICK, el);
				end
			end
			settle();
		end
		idle_pct = 38;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = 1'b0;
		elapsed_us = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		mismatches = 0;
		idle_pct   = 38;
		for (int i = 0; i < MAX_SLOTS_DEF; i++) slot_birth[i] = 32'd0;
		ring_now    = 32'd0;
		ring_frames = 32'd0;
		ring_accum  = 32'd0;
		hd_active   = 0;
		hd_new      = 0;
		hd_free     = 0;
		hd_retired  = 0;
		lim_reg     = SLOT_LIMIT_RST;
		dur_reg     = 32'(DURATION_RST);
		period_reg  = 32'(PERIOD_RST);
		play_reg    = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_on();
		test_ring_full();
		test_emission();
		test_retire_free();
		test_long_run();
		test_random_traffic();

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[particle_ring_lifetime_manager_core] OK");
		end else begin
			$display("[particle_ring_lifetime_manager_core] ERROR");
		end
		$finish;
	end

endmodule
